[rtl/lur_pkg.sv]
package lur_pkg;

    localparam int DEF_FRAME_WIDTH  = 2048;
    localparam int DEF_FRAME_HEIGHT = 2048;

    localparam int CFG_W     = 32;
    localparam int FRAC_W    = 28;
    localparam int Q_W       = 36;
    localparam int SUM_W     = 40;
    localparam int RAW_W     = 2 * Q_W - FRAC_W + 1;
    localparam int U_W       = RAW_W + 2;
    localparam int PIX_W     = 12;
    localparam int COORD_W   = 11;
    localparam int INDEX_W   = 22;
    localparam int DIV_STEPS = 31;

    typedef logic signed [Q_W-1:0] q28_t;

    localparam q28_t SAT_MAX = 36'sh7_FFFF_FFFF;
    localparam q28_t Q28_ONE = 36'sh0_1000_0000;
    localparam logic signed [SUM_W-1:0] SUM_SAT_MAX = 40'sh07_FFFF_FFFF;
    localparam logic signed [SUM_W-1:0] SUM_SAT_MIN = -SUM_SAT_MAX;
    localparam logic signed [U_W-1:0] U_HALF    = U_W'(32768);
    localparam logic signed [U_W-1:0] U_NEG_ONE = -(U_W'(65536));

    typedef enum logic [2:0] {
        REG_FOCAL_X,
        REG_FOCAL_Y,
        REG_CENTER_X,
        REG_CENTER_Y,
        REG_RADIAL_K1,
        REG_RADIAL_K2,
        REG_RADIAL_K3,
        REG_TANGENTIAL
    } reg_idx_t;

    typedef struct packed {
        logic             ok;
        logic [PIX_W-1:0] pix;
    } pix_t;

    function automatic q28_t sat36(input logic signed [SUM_W-1:0] v);
        q28_t r;
        if (v > SUM_SAT_MAX) begin
            r = SAT_MAX;
        end else if (v < SUM_SAT_MIN) begin
            r = -SAT_MAX;
        end else begin
            r = v[Q_W-1:0];
        end
        return r;
    endfunction

    function automatic pix_t to_pixel(input logic signed [RAW_W-1:0] raw,
                                      input logic [CFG_W-1:0] center,
                                      input logic [PIX_W:0] limit);
        logic signed [U_W-1:0] u;
        logic [U_W-17:0] p;
        pix_t res;
        u = U_W'(raw) + $signed(U_W'(center)) + U_HALF;
        p = u[U_W-1:16];
        if (u < 0) begin
            res.ok  = (u > U_NEG_ONE);
            res.pix = '0;
        end else begin
            res.ok  = (p < (U_W-16)'(limit));
            res.pix = p[PIX_W-1:0];
        end
        return res;
    endfunction

endpackage

[rtl/lur_pipe.sv]
module lur_pipe #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 1
) (
    input  logic             aclk,
    input  logic             en,
    input  logic [WIDTH-1:0] din,
    output logic [WIDTH-1:0] dout
);

    logic [WIDTH-1:0] stage_reg [DEPTH];

    always_ff @(posedge aclk) begin
        if (en) begin
            stage_reg[0] <= din;
            for (int i = 1; i < DEPTH; i++) begin
                stage_reg[i] <= stage_reg[i-1];
            end
        end
    end

    assign dout = stage_reg[DEPTH-1];

endmodule

[rtl/lur_mul.sv]
module lur_mul (
    input  logic                              aclk,
    input  logic                              en,
    input  logic signed [lur_pkg::Q_W-1:0]    a,
    input  logic signed [lur_pkg::Q_W-1:0]    b,
    output logic signed [lur_pkg::RAW_W-1:0]  p_raw,
    output logic signed [lur_pkg::Q_W-1:0]    p_sat
);
    import lur_pkg::*;

    localparam int HALF_W = Q_W / 2;
    localparam int PROD_W = 2 * Q_W;
    localparam int MAG_W  = PROD_W - FRAC_W;

    logic [Q_W-1:0]    ma_reg, mb_reg;
    logic              neg1_reg, neg2_reg, neg3_reg;
    logic [Q_W-1:0]    hh_reg, hl_reg, lh_reg, ll_reg;
    logic [PROD_W-1:0] sum_reg;
    logic [MAG_W-1:0]  mag;
    logic [Q_W-1:0]    mag_sat;
    logic signed [RAW_W-1:0] p_raw_reg;
    q28_t              p_sat_reg;

    // magnitude product, truncated toward zero, then sign
    assign mag     = sum_reg[PROD_W-1:FRAC_W];
    assign mag_sat = (mag > MAG_W'(SAT_MAX)) ? Q_W'(SAT_MAX) : Q_W'(mag);

    always_ff @(posedge aclk) begin
        if (en) begin
            ma_reg    <= a[Q_W-1] ? Q_W'(-a) : Q_W'(a);
            mb_reg    <= b[Q_W-1] ? Q_W'(-b) : Q_W'(b);
            neg1_reg  <= a[Q_W-1] ^ b[Q_W-1];
            hh_reg    <= ma_reg[Q_W-1:HALF_W] * mb_reg[Q_W-1:HALF_W];
            hl_reg    <= ma_reg[Q_W-1:HALF_W] * mb_reg[HALF_W-1:0];
            lh_reg    <= ma_reg[HALF_W-1:0] * mb_reg[Q_W-1:HALF_W];
            ll_reg    <= ma_reg[HALF_W-1:0] * mb_reg[HALF_W-1:0];
            neg2_reg  <= neg1_reg;
            sum_reg   <= {hh_reg, ll_reg} + (PROD_W'(hl_reg) << HALF_W)
                         + (PROD_W'(lh_reg) << HALF_W);
            neg3_reg  <= neg2_reg;
            p_raw_reg <= neg3_reg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
            p_sat_reg <= neg3_reg ? -$signed(mag_sat) : $signed(mag_sat);
        end
    end

    assign p_raw = p_raw_reg;
    assign p_sat = p_sat_reg;

endmodule

[rtl/lur_div.sv]
module lur_div (
    input  logic                              aclk,
    input  logic                              en,
    input  logic [lur_pkg::CFG_W-1:0]         focal,
    input  logic [lur_pkg::CFG_W-1:0]         ud,
    output logic [lur_pkg::DIV_STEPS-1:0]     q
);
    import lur_pkg::*;

    // (ud << 28) / focal, restoring, one quotient bit per stage
    logic [CFG_W-1:0]     rem_reg [DIV_STEPS];
    logic [DIV_STEPS-1:0] q_reg   [DIV_STEPS];
    logic [2:0]           lo_reg  [2];

    for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
        logic [CFG_W-1:0]     rem_in;
        logic [DIV_STEPS-1:0] q_in;
        logic                 bit_in;
        logic [CFG_W:0]       trial;

        if (k == 0) begin : g_first
            assign rem_in = {3'b000, ud[CFG_W-1:3]};
            assign q_in   = '0;
        end else begin : g_later
            assign rem_in = rem_reg[k-1];
            assign q_in   = q_reg[k-1];
        end

        if (k < 3) begin : g_head
            logic [2:0] lo_in;
            if (k == 0) begin : g_lo_first
                assign lo_in = ud[2:0];
            end else begin : g_lo_later
                assign lo_in = lo_reg[k-1];
            end
            assign bit_in = lo_in[2-k];
            if (k < 2) begin : g_keep
                always_ff @(posedge aclk) begin
                    if (en) begin
                        lo_reg[k] <= lo_in;
                    end
                end
            end
        end else begin : g_tail
            assign bit_in = 1'b0;
        end

        assign trial = {rem_in, bit_in};

        always_ff @(posedge aclk) begin
            if (en) begin
                if (trial >= {1'b0, focal}) begin
                    rem_reg[k] <= CFG_W'(trial - {1'b0, focal});
                    q_reg[k]   <= {q_in[DIV_STEPS-2:0], 1'b1};
                end else begin
                    rem_reg[k] <= CFG_W'(trial);
                    q_reg[k]   <= {q_in[DIV_STEPS-2:0], 1'b0};
                end
            end
        end
    end

    assign q = q_reg[DIV_STEPS-1];

endmodule

[rtl/lens_undistort_remap_address.sv]
// Lens undistortion remap address generator, nearest neighbor.
// Input stream: one output pixel position per word, s_tdata carries out_col
// and out_row. Result stream: one word per input word, m_tdata carries the
// source column, row and linear index, m_tuser flags a source inside the
// frame (0 means the output pixel is black and the other fields are zero).
// Registers must be written over the APB port only while no word is in flight; the block itself does not enforce this.
// Throughput: one word per clock while m_tready does not stall the pipeline. Each word
// passes through the 31 stage quotient pipeline of the normalization followed by
// the chain of multipliers of the distortion polynomial.
// Reset clears all valid flags and loads the register defaults (unit focal
// lengths, zero center and coefficients); no words are lost or invented.
// When m_tready is low with a result waiting, the whole pipeline holds and
// s_tready drops; s_tready = m_tready | ~m_tvalid.
module lens_undistort_remap_address #(
    parameter int FRAME_WIDTH  = lur_pkg::DEF_FRAME_WIDTH,
    parameter int FRAME_HEIGHT = lur_pkg::DEF_FRAME_HEIGHT
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // out_col[10:0], out_row[21:11], zero pad
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // src_col[10:0], src_row[21:11], src_index[43:22], pad
    output logic        m_tuser,   // in_frame
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [5:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);
    import lur_pkg::*;

    localparam int PIPE_DEPTH = 63;
    localparam int IDX_FULL_W = 2 * PIX_W + 1;

    logic [CFG_W-1:0] focal_x_reg, focal_y_reg, center_x_reg, center_y_reg;
    logic [CFG_W-1:0] k1_reg, k2_reg, k3_reg;
    logic [63:0]      tangential_reg;
    logic             cfg_wr;

    logic adv;
    logic [PIPE_DEPTH-1:0] vld_reg;

    logic signed [33:0] dx_reg, dy_reg;
    logic [CFG_W-1:0]   udx_next, udy_next, udx_reg, udy_reg;
    logic               negx_reg, negy_reg, okn_reg, okn_next;
    logic [DIV_STEPS-1:0] qx, qy;
    logic [1:0]         neg_d;
    logic               okn_d;

    q28_t x1_reg, y1_reg, k1, k2, k3, p1, p2;
    q28_t xx, yy, xy, xx_reg, yy_reg, r2_reg, sx_reg, sy_reg, r2_d;
    q28_t pxy1, pxy2, r4, kr1, p2sx, p1sy, r6, kr2, kr3;
    q28_t kr1_d, kr2_d, g_reg, x1_d, y1_d, xg, yg;
    q28_t pxy1_d, pxy2_d, p2sx_d, p1sy_d, x2_reg, y2_reg;
    logic [2*Q_W-1:0] x1y1_d, pxy_d, ptan_d;
    logic signed [RAW_W-1:0] ux, uy;
    pix_t colp_reg, rowp_reg;

    logic [IDX_FULL_W-1:0] idx_full, chk_index;
    logic                  out_ok;
    logic [47:0]           m_tdata_reg;
    logic                  m_tuser_reg;

    // configuration
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            focal_x_reg    <= CFG_W'(65536);
            focal_y_reg    <= CFG_W'(65536);
            center_x_reg   <= '0;
            center_y_reg   <= '0;
            k1_reg         <= '0;
            k2_reg         <= '0;
            k3_reg         <= '0;
            tangential_reg <= '0;
        end else if (cfg_wr) begin
            unique case (reg_idx_t'(paddr[5:3]))
                REG_FOCAL_X:    focal_x_reg    <= pwdata[CFG_W-1:0];
                REG_FOCAL_Y:    focal_y_reg    <= pwdata[CFG_W-1:0];
                REG_CENTER_X:   center_x_reg   <= pwdata[CFG_W-1:0];
                REG_CENTER_Y:   center_y_reg   <= pwdata[CFG_W-1:0];
                REG_RADIAL_K1:  k1_reg         <= pwdata[CFG_W-1:0];
                REG_RADIAL_K2:  k2_reg         <= pwdata[CFG_W-1:0];
                REG_RADIAL_K3:  k3_reg         <= pwdata[CFG_W-1:0];
                REG_TANGENTIAL: tangential_reg <= pwdata;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx_t'(paddr[5:3]))
            REG_FOCAL_X:    prdata = {32'b0, focal_x_reg};
            REG_FOCAL_Y:    prdata = {32'b0, focal_y_reg};
            REG_CENTER_X:   prdata = {32'b0, center_x_reg};
            REG_CENTER_Y:   prdata = {32'b0, center_y_reg};
            REG_RADIAL_K1:  prdata = {32'b0, k1_reg};
            REG_RADIAL_K2:  prdata = {32'b0, k2_reg};
            REG_RADIAL_K3:  prdata = {32'b0, k3_reg};
            REG_TANGENTIAL: prdata = tangential_reg;
        endcase
    end

    assign k1 = Q_W'($signed(k1_reg));
    assign k2 = Q_W'($signed(k2_reg));
    assign k3 = Q_W'($signed(k3_reg));
    assign p1 = Q_W'($signed(tangential_reg[31:0]));
    assign p2 = Q_W'($signed(tangential_reg[63:32]));

    // flow control: the whole pipeline moves together
    assign adv      = m_tready | ~m_tvalid;
    assign s_tready = adv;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= {vld_reg[PIPE_DEPTH-2:0], s_tvalid};
        end
    end

    // normalization front end
    assign udx_next = dx_reg[33] ? CFG_W'(-dx_reg) : CFG_W'(dx_reg);
    assign udy_next = dy_reg[33] ? CFG_W'(-dy_reg) : CFG_W'(dy_reg);
    // quotient fits Q4.28 iff ud < 8 * focal (also false for zero focal)
    assign okn_next = (35'(udx_next) < {focal_x_reg, 3'b000})
                    & (35'(udy_next) < {focal_y_reg, 3'b000});

    always_ff @(posedge aclk) begin
        if (adv) begin
            dx_reg   <= $signed(34'({s_tdata[COORD_W-1:0], 16'b0}) - 34'(center_x_reg));
            dy_reg   <= $signed(34'({s_tdata[2*COORD_W-1:COORD_W], 16'b0})
                                - 34'(center_y_reg));
            udx_reg  <= udx_next;
            udy_reg  <= udy_next;
            negx_reg <= dx_reg[33];
            negy_reg <= dy_reg[33];
            okn_reg  <= okn_next;
        end
    end

    lur_div u_div_x (.aclk(aclk), .en(adv), .focal(focal_x_reg), .ud(udx_reg), .q(qx));
    lur_div u_div_y (.aclk(aclk), .en(adv), .focal(focal_y_reg), .ud(udy_reg), .q(qy));

    lur_pipe #(.WIDTH(2), .DEPTH(DIV_STEPS)) u_neg_dly (
        .aclk(aclk), .en(adv), .din({negx_reg, negy_reg}), .dout(neg_d));
    lur_pipe #(.WIDTH(1), .DEPTH(PIPE_DEPTH - 3)) u_ok_dly (
        .aclk(aclk), .en(adv), .din(okn_reg), .dout(okn_d));

    always_ff @(posedge aclk) begin
        if (adv) begin
            x1_reg <= neg_d[1] ? -$signed(Q_W'(qx)) : $signed(Q_W'(qx));
            y1_reg <= neg_d[0] ? -$signed(Q_W'(qy)) : $signed(Q_W'(qy));
        end
    end

    // radial and tangential polynomial
    lur_mul u_xx (.aclk(aclk), .en(adv), .a(x1_reg), .b(x1_reg), .p_raw(), .p_sat(xx));
    lur_mul u_yy (.aclk(aclk), .en(adv), .a(y1_reg), .b(y1_reg), .p_raw(), .p_sat(yy));
    lur_mul u_xy (.aclk(aclk), .en(adv), .a(x1_reg), .b(y1_reg), .p_raw(), .p_sat(xy));

    always_ff @(posedge aclk) begin
        if (adv) begin
            r2_reg <= sat36(SUM_W'(xx) + SUM_W'(yy));
            xx_reg <= xx;
            yy_reg <= yy;
            sx_reg <= sat36(SUM_W'(r2_reg) + (SUM_W'(xx_reg) <<< 1));
            sy_reg <= sat36(SUM_W'(r2_reg) + (SUM_W'(yy_reg) <<< 1));
        end
    end

    lur_mul u_pxy1 (.aclk(aclk), .en(adv), .a(p1), .b(xy), .p_raw(), .p_sat(pxy1));
    lur_mul u_pxy2 (.aclk(aclk), .en(adv), .a(p2), .b(xy), .p_raw(), .p_sat(pxy2));
    lur_mul u_r4   (.aclk(aclk), .en(adv), .a(r2_reg), .b(r2_reg), .p_raw(), .p_sat(r4));
    lur_mul u_kr1  (.aclk(aclk), .en(adv), .a(k1), .b(r2_reg), .p_raw(), .p_sat(kr1));
    lur_mul u_p2sx (.aclk(aclk), .en(adv), .a(p2), .b(sx_reg), .p_raw(), .p_sat(p2sx));
    lur_mul u_p1sy (.aclk(aclk), .en(adv), .a(p1), .b(sy_reg), .p_raw(), .p_sat(p1sy));

    lur_pipe #(.WIDTH(Q_W), .DEPTH(4)) u_r2_dly (
        .aclk(aclk), .en(adv), .din(r2_reg), .dout(r2_d));

    lur_mul u_r6  (.aclk(aclk), .en(adv), .a(r4), .b($signed(r2_d)), .p_raw(), .p_sat(r6));
    lur_mul u_kr2 (.aclk(aclk), .en(adv), .a(k2), .b(r4), .p_raw(), .p_sat(kr2));
    lur_mul u_kr3 (.aclk(aclk), .en(adv), .a(k3), .b(r6), .p_raw(), .p_sat(kr3));

    lur_pipe #(.WIDTH(Q_W), .DEPTH(8)) u_kr1_dly (
        .aclk(aclk), .en(adv), .din(kr1), .dout(kr1_d));
    lur_pipe #(.WIDTH(Q_W), .DEPTH(4)) u_kr2_dly (
        .aclk(aclk), .en(adv), .din(kr2), .dout(kr2_d));

    always_ff @(posedge aclk) begin
        if (adv) begin
            g_reg <= sat36(SUM_W'(Q28_ONE) + SUM_W'($signed(kr1_d))
                           + SUM_W'($signed(kr2_d)) + SUM_W'(kr3));
        end
    end

    lur_pipe #(.WIDTH(2*Q_W), .DEPTH(18)) u_x1y1_dly (
        .aclk(aclk), .en(adv), .din({x1_reg, y1_reg}), .dout(x1y1_d));
    assign x1_d = $signed(x1y1_d[2*Q_W-1:Q_W]);
    assign y1_d = $signed(x1y1_d[Q_W-1:0]);

    lur_mul u_xg (.aclk(aclk), .en(adv), .a(x1_d), .b(g_reg), .p_raw(), .p_sat(xg));
    lur_mul u_yg (.aclk(aclk), .en(adv), .a(y1_d), .b(g_reg), .p_raw(), .p_sat(yg));

    lur_pipe #(.WIDTH(2*Q_W), .DEPTH(14)) u_pxy_dly (
        .aclk(aclk), .en(adv), .din({pxy1, pxy2}), .dout(pxy_d));
    lur_pipe #(.WIDTH(2*Q_W), .DEPTH(12)) u_ptan_dly (
        .aclk(aclk), .en(adv), .din({p2sx, p1sy}), .dout(ptan_d));
    assign pxy1_d = $signed(pxy_d[2*Q_W-1:Q_W]);
    assign pxy2_d = $signed(pxy_d[Q_W-1:0]);
    assign p2sx_d = $signed(ptan_d[2*Q_W-1:Q_W]);
    assign p1sy_d = $signed(ptan_d[Q_W-1:0]);

    always_ff @(posedge aclk) begin
        if (adv) begin
            x2_reg <= sat36(SUM_W'(xg) + (SUM_W'(pxy1_d) <<< 1) + SUM_W'(p2sx_d));
            y2_reg <= sat36(SUM_W'(yg) + SUM_W'(p1sy_d) + (SUM_W'(pxy2_d) <<< 1));
        end
    end

    // back to pixel space
    lur_mul u_ux (.aclk(aclk), .en(adv), .a(x2_reg), .b($signed(Q_W'(focal_x_reg))),
                  .p_raw(ux), .p_sat());
    lur_mul u_uy (.aclk(aclk), .en(adv), .a(y2_reg), .b($signed(Q_W'(focal_y_reg))),
                  .p_raw(uy), .p_sat());

    assign out_ok   = okn_d & colp_reg.ok & rowp_reg.ok;
    assign idx_full = IDX_FULL_W'(rowp_reg.pix) * IDX_FULL_W'(FRAME_WIDTH)
                    + IDX_FULL_W'(colp_reg.pix);

    always_ff @(posedge aclk) begin
        if (adv) begin
            colp_reg    <= to_pixel(ux, center_x_reg, (PIX_W+1)'(FRAME_WIDTH));
            rowp_reg    <= to_pixel(uy, center_y_reg, (PIX_W+1)'(FRAME_HEIGHT));
            m_tdata_reg <= out_ok ? {4'b0, idx_full[INDEX_W-1:0],
                                     rowp_reg.pix[COORD_W-1:0],
                                     colp_reg.pix[COORD_W-1:0]} : '0;
            m_tuser_reg <= out_ok;
        end
    end

    assign m_tvalid = vld_reg[PIPE_DEPTH-1];
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    assign chk_index = IDX_FULL_W'(m_tdata[21:11]) * IDX_FULL_W'(FRAME_WIDTH)
                     + IDX_FULL_W'(m_tdata[10:0]);

    a_black_is_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_tdata == '0)
        else $error("out of frame result carries nonzero fields");

    a_index_match: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata[43:22] == chk_index[INDEX_W-1:0])
        else $error("source index does not match row and column");

    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |-> !s_tready)
        else $error("input taken while pipeline is stalled");

endmodule
